// ----- design/plcrw_pkg.sv -----
// Shared types, constants and register indexes of the PLC read/write response parser.
package plcrw_pkg;

   localparam int MAX_FRAME_DEFAULT = 8192;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_RESPONSE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_REFERENCE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_CAPACITY = 2'd2;

   localparam logic [15:0] READ_CAPACITY_RESET = 16'd8192;

   localparam logic [7:0] TPKT_VERSION = 8'h03;
   localparam logic [7:0] TPKT_RESERVED = 8'h00;
   localparam logic [7:0] COTP_CONNECT_CONFIRM = 8'hd0;
   localparam logic [7:0] MSG_ACK = 8'h02;
   localparam logic [7:0] MSG_ACK_DATA = 8'h03;
   localparam logic [7:0] FUNC_SETUP = 8'hf0;
   localparam logic [7:0] FUNC_READ = 8'h04;
   localparam logic [7:0] FUNC_WRITE = 8'h05;
   localparam logic [7:0] RETURN_SUCCESS = 8'hff;

   localparam logic [4:0] OFFSET_ACK_DATA = 5'd19;
   localparam logic [4:0] OFFSET_ACK = 5'd17;
   localparam logic [15:0] MIN_PDU_FRAME = 16'd21;
   localparam logic [15:0] MIN_CONNECT_FRAME = 16'd11;
   localparam logic [15:0] MIN_DECLARED = 16'd7;
   localparam logic [15:0] MIN_HEADER = 16'd4;
   localparam logic [15:0] PDU_LENGTH_MIN = 16'd240;
   localparam logic [15:0] PDU_LENGTH_MAX = 16'd4096;

   localparam logic [7:0] PDU_HEAD [4] = '{8'h02, 8'hf0, 8'h80, 8'h32};

   typedef enum logic [1:0] {
      RESP_CONNECT = 2'd0,
      RESP_SETUP = 2'd1,
      RESP_READ = 2'd2,
      RESP_WRITE = 2'd3
   } resp_type;

   typedef enum logic [2:0] {
      STATUS_OK = 3'd0,
      STATUS_TRUNCATED = 3'd1,
      STATUS_WRONG = 3'd2,
      STATUS_PROTOCOL = 3'd3,
      STATUS_DENIED = 3'd4,
      STATUS_TOO_SMALL = 3'd5
   } status_type;

   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] declared_length;
      logic        header_ok;
      logic [7:0]  message_type;
      logic [7:0]  pdu_type;
      logic [15:0] echoed_reference;
      logic [15:0] param_length;
      logic [15:0] data_length;
      logic [15:0] ack_error;
      logic [7:0]  item_count;
      logic [15:0] pdu_length;
      logic [7:0]  rc_byte;
      logic [13:0] data_bytes;
   } frame_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  rc_byte;
      logic [12:0] negotiated_pdu;
      logic [15:0] read_byte_count;
   } verdict_type;

endpackage

// ----- design/plcrw_stream_if.sv -----
// Request and response channel interfaces of the PLC read/write response parser.
interface plcrw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface plcrw_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        verdict_valid;
   logic [2:0]  status;
   logic [7:0]  item_return_code;
   logic [12:0] negotiated_pdu;
   logic [15:0] read_byte_count;

   modport source (output valid, output payload_byte, output payload_valid,
                   output verdict_valid, output status, output item_return_code,
                   output negotiated_pdu, output read_byte_count, input ready);
   modport sink (input valid, input payload_byte, input payload_valid,
                 input verdict_valid, input status, input item_return_code,
                 input negotiated_pdu, input read_byte_count, output ready);
endinterface

// ----- design/plcrw_judge.sv -----
// Final frame verdict from the captured header fields and the configuration.
module plcrw_judge #(
   parameter int MAX_FRAME = plcrw_pkg::MAX_FRAME_DEFAULT
) (
   input  plcrw_pkg::frame_type   frame,
   input  plcrw_pkg::resp_type    expected_response,
   input  logic [15:0]            expected_reference,
   input  logic [15:0]            read_capacity,
   output plcrw_pkg::verdict_type verdict
);

   logic [4:0]  offset;
   logic [7:0]  func_code;
   logic [17:0] length_sum;
   logic [16:0] bytes_plus_four;
   logic [16:0] data_end;
   logic        is_ack_data;

   always_comb begin
      is_ack_data = frame.message_type == plcrw_pkg::MSG_ACK_DATA;
      offset = is_ack_data ? plcrw_pkg::OFFSET_ACK_DATA : plcrw_pkg::OFFSET_ACK;
      case (expected_response)
         plcrw_pkg::RESP_SETUP: func_code = plcrw_pkg::FUNC_SETUP;
         plcrw_pkg::RESP_READ: func_code = plcrw_pkg::FUNC_READ;
         default: func_code = plcrw_pkg::FUNC_WRITE;
      endcase
      length_sum = 18'(offset) + 18'(frame.param_length) + 18'(frame.data_length);
      bytes_plus_four = 17'(frame.data_bytes) + 17'd4;
      data_end = 17'(offset) + 17'd6 + 17'(frame.data_bytes);
   end

   always_comb begin
      verdict.status = plcrw_pkg::STATUS_OK;
      verdict.rc_byte = '0;
      verdict.negotiated_pdu = '0;
      verdict.read_byte_count = '0;
      if (frame.byte_count < plcrw_pkg::MIN_HEADER) begin
         verdict.status = plcrw_pkg::STATUS_TRUNCATED;
      end else if (!frame.header_ok || frame.declared_length < plcrw_pkg::MIN_DECLARED ||
                   frame.declared_length > 16'(MAX_FRAME) ||
                   frame.declared_length != frame.byte_count) begin
         verdict.status = plcrw_pkg::STATUS_WRONG;
      end else if (expected_response == plcrw_pkg::RESP_CONNECT) begin
         if (frame.byte_count < plcrw_pkg::MIN_CONNECT_FRAME) begin
            verdict.status = plcrw_pkg::STATUS_WRONG;
         end
      end else if (frame.byte_count < plcrw_pkg::MIN_PDU_FRAME ||
                   (frame.message_type != plcrw_pkg::MSG_ACK && !is_ack_data) ||
                   frame.echoed_reference != expected_reference) begin
         verdict.status = plcrw_pkg::STATUS_WRONG;
      end else if (length_sum != 18'(frame.byte_count) || frame.param_length < 16'd2 ||
                   frame.pdu_type != func_code) begin
         verdict.status = plcrw_pkg::STATUS_WRONG;
      end else if (is_ack_data && frame.ack_error != 16'd0) begin
         verdict.status = plcrw_pkg::STATUS_PROTOCOL;
      end else if (expected_response == plcrw_pkg::RESP_SETUP) begin
         if (frame.param_length != 16'd8 || frame.data_length != 16'd0 ||
             frame.pdu_length < plcrw_pkg::PDU_LENGTH_MIN ||
             frame.pdu_length > plcrw_pkg::PDU_LENGTH_MAX) begin
            verdict.status = plcrw_pkg::STATUS_WRONG;
         end else begin
            verdict.negotiated_pdu = frame.pdu_length[12:0];
         end
      end else if (frame.param_length != 16'd2 || frame.item_count != 8'd1) begin
         verdict.status = plcrw_pkg::STATUS_WRONG;
      end else if (expected_response == plcrw_pkg::RESP_READ) begin
         if (frame.data_length < 16'd4) begin
            verdict.status = plcrw_pkg::STATUS_WRONG;
         end else begin
            verdict.rc_byte = frame.rc_byte;
            if (frame.rc_byte != plcrw_pkg::RETURN_SUCCESS) begin
               verdict.status = plcrw_pkg::STATUS_DENIED;
            end else if (bytes_plus_four > 17'(frame.data_length) ||
                         data_end > 17'(frame.byte_count)) begin
               verdict.status = plcrw_pkg::STATUS_WRONG;
            end else if (read_capacity < 16'(frame.data_bytes)) begin
               verdict.status = plcrw_pkg::STATUS_TOO_SMALL;
            end else begin
               verdict.read_byte_count = 16'(frame.data_bytes);
            end
         end
      end else if (frame.data_length != 16'd1) begin
         verdict.status = plcrw_pkg::STATUS_WRONG;
      end else begin
         verdict.rc_byte = frame.rc_byte;
         if (frame.rc_byte != plcrw_pkg::RETURN_SUCCESS) begin
            verdict.status = plcrw_pkg::STATUS_DENIED;
         end
      end
   end

endmodule

// ----- design/plc_read_write_response_parser.sv -----
// Top level of the PLC read/write response parser: field capture, data streaming, result register.
//
// The parser takes one frame byte per cycle when ready; it needs no gaps between bytes or frames.
// Each accepted byte updates the captured header fields and, on the last byte of a frame or on
// a read data byte, loads one response into the output register in the same cycle, so the
// response appears in the cycle after its byte. The request channel stays ready while the output
// register is empty or being drained, so a waiting response stalls input only when the consumer
// also holds off. Read data bytes stream out as they arrive; keep them only when the verdict that
// ends the frame reports ok. Configuration writes take effect at the next clock edge.
module plc_read_write_response_parser #(
   parameter int MAX_FRAME = plcrw_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   plcrw_req_if.sink                              req_if,
   plcrw_rsp_if.source                            rsp_if,
   input  logic                                   csr_we,
   input  logic [plcrw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [plcrw_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   plcrw_pkg::resp_type    expected_response_ff;
   logic [15:0]            expected_reference_ff;
   logic [15:0]            read_capacity_ff;

   plcrw_pkg::frame_type   frame_ff;
   plcrw_pkg::frame_type   frame_in;
   plcrw_pkg::frame_type   frame_clear;
   logic [15:0]            encoded_bits_ff;
   logic [15:0]            encoded_bits_in;
   plcrw_pkg::verdict_type verdict;

   logic        rsp_valid_ff;
   logic [7:0]  payload_byte_ff;
   logic        payload_valid_ff;
   logic        verdict_valid_ff;
   plcrw_pkg::verdict_type verdict_ff;

   logic [15:0] idx;
   logic [7:0]  b;
   logic [4:0]  offset;
   logic [15:0] off16;
   logic [16:0] bits_round;
   logic [16:0] data_stop;
   logic        stream_byte;
   logic        accept;
   logic        produce;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      frame_clear = '0;
      frame_clear.header_ok = 1'b1;
   end

   always_comb begin
      idx = frame_ff.byte_count;
      b = req_if.frame_byte;
      frame_in = frame_ff;
      encoded_bits_in = encoded_bits_ff;
      if (frame_ff.byte_count != 16'hffff) begin
         frame_in.byte_count = frame_ff.byte_count + 16'd1;
      end
      if (idx == 16'd0 && b != plcrw_pkg::TPKT_VERSION) frame_in.header_ok = 1'b0;
      if (idx == 16'd1 && b != plcrw_pkg::TPKT_RESERVED) frame_in.header_ok = 1'b0;
      if (idx == 16'd2) frame_in.declared_length[15:8] = b;
      if (idx == 16'd3) frame_in.declared_length[7:0] = b;
      if (idx >= 16'd4 && idx <= 16'd7) begin
         if (expected_response_ff != plcrw_pkg::RESP_CONNECT &&
             b != plcrw_pkg::PDU_HEAD[idx[1:0]]) begin
            frame_in.header_ok = 1'b0;
         end
         if (expected_response_ff == plcrw_pkg::RESP_CONNECT && idx == 16'd5 &&
             b != plcrw_pkg::COTP_CONNECT_CONFIRM) begin
            frame_in.header_ok = 1'b0;
         end
      end
      if (idx == 16'd8) frame_in.message_type = b;
      if (idx == 16'd11) frame_in.echoed_reference[15:8] = b;
      if (idx == 16'd12) frame_in.echoed_reference[7:0] = b;
      if (idx == 16'd13) frame_in.param_length[15:8] = b;
      if (idx == 16'd14) frame_in.param_length[7:0] = b;
      if (idx == 16'd15) frame_in.data_length[15:8] = b;
      if (idx == 16'd16) frame_in.data_length[7:0] = b;
      if (idx == 16'd17) frame_in.ack_error[15:8] = b;
      if (idx == 16'd18) frame_in.ack_error[7:0] = b;

      offset = frame_in.message_type == plcrw_pkg::MSG_ACK_DATA ?
               plcrw_pkg::OFFSET_ACK_DATA : plcrw_pkg::OFFSET_ACK;
      off16 = 16'(offset);
      if (idx == off16) frame_in.pdu_type = b;
      if (idx == off16 + 16'd1) frame_in.item_count = b;
      if (idx == off16 + 16'd2) frame_in.rc_byte = b;
      if (idx == off16 + 16'd4) encoded_bits_in[15:8] = b;
      if (idx == off16 + 16'd5) encoded_bits_in[7:0] = b;
      if (idx == off16 + 16'd6) frame_in.pdu_length[15:8] = b;
      if (idx == off16 + 16'd7) frame_in.pdu_length[7:0] = b;

      bits_round = 17'(encoded_bits_in) + 17'd7;
      frame_in.data_bytes = bits_round[16:3];
      data_stop = 17'(off16) + 17'd6 + 17'(frame_in.data_bytes);
      stream_byte = expected_response_ff == plcrw_pkg::RESP_READ &&
                    idx >= off16 + 16'd6 && 17'(idx) < data_stop;
      produce = req_if.frame_end || stream_byte;
   end

   plcrw_judge #(
      .MAX_FRAME(MAX_FRAME)
   ) u_judge (
      .frame(frame_in),
      .expected_response(expected_response_ff),
      .expected_reference(expected_reference_ff),
      .read_capacity(read_capacity_ff),
      .verdict(verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_response_ff <= plcrw_pkg::RESP_CONNECT;
         expected_reference_ff <= '0;
         read_capacity_ff <= plcrw_pkg::READ_CAPACITY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            plcrw_pkg::CSR_EXPECTED_RESPONSE:
               expected_response_ff <= plcrw_pkg::resp_type'(csr_wdata[1:0]);
            plcrw_pkg::CSR_EXPECTED_REFERENCE: expected_reference_ff <= csr_wdata;
            plcrw_pkg::CSR_READ_CAPACITY: read_capacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= frame_clear;
         encoded_bits_ff <= '0;
      end else if (accept) begin
         if (req_if.frame_end) begin
            frame_ff <= frame_clear;
            encoded_bits_ff <= '0;
         end else begin
            frame_ff <= frame_in;
            encoded_bits_ff <= encoded_bits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         payload_byte_ff <= stream_byte ? b : 8'd0;
         payload_valid_ff <= stream_byte;
         verdict_valid_ff <= req_if.frame_end;
         if (req_if.frame_end) begin
            verdict_ff <= verdict;
         end else begin
            verdict_ff <= '0;
         end
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload_byte = payload_byte_ff;
   assign rsp_if.payload_valid = payload_valid_ff;
   assign rsp_if.verdict_valid = verdict_valid_ff;
   assign rsp_if.status = verdict_ff.status;
   assign rsp_if.item_return_code = verdict_ff.rc_byte;
   assign rsp_if.negotiated_pdu = verdict_ff.negotiated_pdu;
   assign rsp_if.read_byte_count = verdict_ff.read_byte_count;

endmodule
